// ===== sv/lcgfy_pkg.sv =====
// Shared constants, command and status types for the LCG deck shuffler.
`timescale 1ns / 1ps

package lcgfy_pkg;

	// Deck geometry.
	localparam int DECK_SIZE = 64;
	localparam int IDX_W     = $clog2(DECK_SIZE);
	localparam int DIV_W     = IDX_W + 1;

	// Generator recurrence and draw extraction.
	localparam logic [31:0] LCG_MULT = 32'd214013;
	localparam logic [31:0] LCG_INC  = 32'd2531011;
	localparam int DRAW_LSB = 16;
	localparam int DRAW_W   = 15;
	localparam int DCNT_W   = $clog2(DRAW_W);

	// Controller states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_JUMP_TEST,
		ST_ACCM_MUL,
		ST_ACCM_WB,
		ST_ACCA_MUL,
		ST_ACCA_WB,
		ST_CURA_MUL,
		ST_CURA_WB,
		ST_CURM_MUL,
		ST_CURM_WB,
		ST_SEED_MUL,
		ST_SEED_WB,
		ST_INIT,
		ST_DRAW_MUL,
		ST_DRAW_WB,
		ST_DIV,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

	// Operations of the shared multiplier and of its writeback adder.
	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_ACC_M,
		MOP_ACC_A,
		MOP_CUR_A,
		MOP_CUR_M,
		MOP_SEED,
		MOP_DRAW
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    start_load;
		mul_op_t mul_op;
		mul_op_t wb_op;
		logic    idx_clear;
		logic    idx_inc;
		logic    init_wr;
		logic    div_step;
		logic    rd_j;
		logic    hold_ti;
		logic    wr_i;
		logic    wr_j;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic cnt_bit0;
		logic idx_last;
		logic idx_shuf_last;
		logic div_last;
	} status_t;

endpackage

// ===== sv/lcg_fisher_yates_deck_shuffle.sv =====
// Top level of the LCG-driven Fisher-Yates deck shuffler.
`timescale 1ns / 1ps
//
// Usage: a transfer on the start channel (start_valid, start_stall, discard_count)
// begins one shuffle. The block first advances its 32-bit generator discard_count
// times (negative counts skip nothing) by jump-ahead on the shared multiplier,
// one square-and-multiply round for each bit of the count. It then fills the
// 64-entry deck store and runs 63 swap steps, each with a draw, a remainder
// division, and reads and writes through the single read port of the deck RAM.
// Last it offers the 64 slots in order on the card channel (card_valid,
// card_stall), one card at a time, with last high on slot 63.
// start_stall stays high from the start transfer until the final card transfer.
// While card_stall is high the offered card holds and the block waits.
// Reset returns the controller to idle and sets the generator seed to one; the
// seed then carries over from one start to the next. The deck store needs no
// clearing, since every start rewrites it before reading.

module lcg_fisher_yates_deck_shuffle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start_valid,
	output logic               start_stall,
	input  logic signed [31:0] discard_count,
	output logic               card_valid,
	input  logic               card_stall,
	output logic [5:0]         position,
	output logic [5:0]         card_index,
	output logic [1:0]         operation,
	output logic [2:0]         rank,
	output logic [1:0]         letter,
	output logic               last
);

	lcgfy_pkg::cmd_t    cmd;
	lcgfy_pkg::status_t st;

	// Sequencing.
	lcgfy_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (start_valid),
		.start_stall (start_stall),
		.card_valid  (card_valid),
		.card_stall  (card_stall),
		.cmd         (cmd),
		.st          (st)
	);

	// Arithmetic and deck storage.
	lcgfy_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.discard_count (discard_count),
		.cmd           (cmd),
		.st            (st),
		.position      (position),
		.card_index    (card_index),
		.operation     (operation),
		.rank          (rank),
		.letter        (letter),
		.last          (last)
	);

endmodule

// ===== sv/lcgfy_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lcgfy_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lcgfy_datapath.sv =====
// Datapath: generator, jump-ahead registers, shared multiplier, divider and deck store.
`timescale 1ns / 1ps

module lcgfy_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic signed [31:0]     discard_count,
	input  lcgfy_pkg::cmd_t        cmd,
	output lcgfy_pkg::status_t     st,
	output logic [5:0]             position,
	output logic [5:0]             card_index,
	output logic [1:0]             operation,
	output logic [2:0]             rank,
	output logic [1:0]             letter,
	output logic                   last
);

	localparam int IDX_W  = lcgfy_pkg::IDX_W;
	localparam int DIV_W  = lcgfy_pkg::DIV_W;
	localparam int DRAW_W = lcgfy_pkg::DRAW_W;
	localparam int DCNT_W = lcgfy_pkg::DCNT_W;

	logic [31:0]       seed_q;
	logic [30:0]       cnt_q;
	logic [31:0]       acc_m_q;
	logic [31:0]       acc_a_q;
	logic [31:0]       cur_m_q;
	logic [31:0]       cur_a_q;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [31:0]       product;
	logic [31:0]       prod_q;
	logic [31:0]       addend;
	logic [31:0]       wb_sum;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_idx;
	logic [DRAW_W-1:0] num_q;
	logic [IDX_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DIV_W-1:0]  divisor;
	logic [DIV_W-1:0]  trial;
	logic [DIV_W-1:0]  trial_sub;
	logic [IDX_W-1:0]  t_i_q;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [IDX_W-1:0]  ram_rdata;

	// Operand selection for the shared 32-bit multiplier (low word kept).
	always_comb begin
		case (cmd.mul_op)
			lcgfy_pkg::MOP_ACC_M: begin
				mul_a = acc_m_q;
				mul_b = cur_m_q;
			end
			lcgfy_pkg::MOP_ACC_A: begin
				mul_a = acc_a_q;
				mul_b = cur_m_q;
			end
			lcgfy_pkg::MOP_CUR_A: begin
				mul_a = cur_m_q;
				mul_b = cur_a_q;
			end
			lcgfy_pkg::MOP_CUR_M: begin
				mul_a = cur_m_q;
				mul_b = cur_m_q;
			end
			lcgfy_pkg::MOP_SEED: begin
				mul_a = acc_m_q;
				mul_b = seed_q;
			end
			lcgfy_pkg::MOP_DRAW: begin
				mul_a = seed_q;
				mul_b = lcgfy_pkg::LCG_MULT;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// Product register between the multiplier and the writeback adder.
	always_ff @(posedge clk) begin
		if (cmd.mul_op != lcgfy_pkg::MOP_NONE) begin
			prod_q <= product;
		end
	end

	// Writeback adder: the addend depends on the target.
	always_comb begin
		case (cmd.wb_op)
			lcgfy_pkg::MOP_ACC_A: addend = cur_a_q;
			lcgfy_pkg::MOP_CUR_A: addend = cur_a_q;
			lcgfy_pkg::MOP_SEED:  addend = acc_a_q;
			lcgfy_pkg::MOP_DRAW:  addend = lcgfy_pkg::LCG_INC;
			default:              addend = 32'd0;
		endcase
	end

	assign wb_sum = prod_q + addend;

	// Generator seed, which persists across starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd1;
		end else if (cmd.wb_op == lcgfy_pkg::MOP_SEED || cmd.wb_op == lcgfy_pkg::MOP_DRAW) begin
			seed_q <= wb_sum;
		end
	end

	// Jump-ahead accumulators: square-and-multiply over the bits of the count.
	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			cnt_q   <= discard_count[31] ? 31'd0 : discard_count[30:0];
			acc_m_q <= 32'd1;
			acc_a_q <= 32'd0;
			cur_m_q <= lcgfy_pkg::LCG_MULT;
			cur_a_q <= lcgfy_pkg::LCG_INC;
		end else begin
			case (cmd.wb_op)
				lcgfy_pkg::MOP_ACC_M: acc_m_q <= wb_sum;
				lcgfy_pkg::MOP_ACC_A: acc_a_q <= wb_sum;
				lcgfy_pkg::MOP_CUR_A: cur_a_q <= wb_sum;
				lcgfy_pkg::MOP_CUR_M: begin
					cur_m_q <= wb_sum;
					cnt_q   <= cnt_q >> 1;
				end
				default: begin
				end
			endcase
		end
	end

	// Slot counter shared by the fill, shuffle and emit phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.idx_clear) begin
			i_q <= '0;
		end else if (cmd.idx_inc) begin
			i_q <= i_q + 1'b1;
		end
	end

	// Restoring divider, one quotient bit a cycle; only the remainder is kept.
	assign divisor   = DIV_W'(lcgfy_pkg::DECK_SIZE) - {1'b0, i_q};
	assign trial     = {rem_q, num_q[DRAW_W-1]};
	assign trial_sub = trial - divisor;

	always_ff @(posedge clk) begin
		if (cmd.wb_op == lcgfy_pkg::MOP_DRAW) begin
			num_q  <= wb_sum[lcgfy_pkg::DRAW_LSB +: DRAW_W];
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q  <= num_q << 1;
			rem_q  <= (trial >= divisor) ? trial_sub[IDX_W-1:0] : trial[IDX_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// Swap partner slot.
	assign j_idx = i_q + rem_q;

	// Holding register for the entry at slot i during a swap.
	always_ff @(posedge clk) begin
		if (cmd.hold_ti) begin
			t_i_q <= ram_rdata;
		end
	end

	// Deck store ports.
	assign ram_we    = cmd.init_wr | cmd.wr_i | cmd.wr_j;
	assign ram_waddr = cmd.wr_j ? j_idx : i_q;
	assign ram_wdata = cmd.init_wr ? i_q : (cmd.wr_i ? ram_rdata : t_i_q);
	assign ram_raddr = cmd.rd_j ? j_idx : i_q;

	lcgfy_ram #(
		.WIDTH (IDX_W),
		.DEPTH (lcgfy_pkg::DECK_SIZE)
	) u_deck_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register with the decoded card fields.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			position   <= i_q;
			card_index <= ram_rdata;
			operation  <= ram_rdata[5:4];
			rank       <= {1'b0, ram_rdata[3:2]} + 3'd1;
			letter     <= ram_rdata[1:0];
			last       <= st.idx_last;
		end
	end

	// Status toward the controller.
	assign st.cnt_zero      = (cnt_q == 31'd0);
	assign st.cnt_bit0      = cnt_q[0];
	assign st.idx_last      = (i_q == IDX_W'(lcgfy_pkg::DECK_SIZE - 1));
	assign st.idx_shuf_last = (i_q == IDX_W'(lcgfy_pkg::DECK_SIZE - 2));
	assign st.div_last      = (dcnt_q == DCNT_W'(DRAW_W - 1));

	// The remainder left by the divider is below the divisor.
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && st.div_last) |=> ({1'b0, rem_q} < divisor))
		else $error("divider remainder not below divisor");

	// A swap partner never lies past the end of the deck.
	a_swap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_j |-> (({1'b0, i_q} + {1'b0, rem_q}) < DIV_W'(lcgfy_pkg::DECK_SIZE)))
		else $error("swap partner outside the deck");

	// The seed changes only on a seed or draw writeback.
	a_seed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wb_op != lcgfy_pkg::MOP_SEED && cmd.wb_op != lcgfy_pkg::MOP_DRAW)
		|=> $stable(seed_q))
		else $error("seed changed outside a writeback");

endmodule

// ===== sv/lcgfy_ctrl.sv =====
// Controller state machine sequencing skip, fill, shuffle and emit phases.
`timescale 1ns / 1ps

module lcgfy_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start_valid,
	output logic               start_stall,
	output logic               card_valid,
	input  logic               card_stall,
	output lcgfy_pkg::cmd_t    cmd,
	input  lcgfy_pkg::status_t st
);

	lcgfy_pkg::state_t state_q;
	lcgfy_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcgfy_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcgfy_pkg::ST_IDLE: begin
				if (start_valid) state_d = lcgfy_pkg::ST_JUMP_TEST;
			end
			lcgfy_pkg::ST_JUMP_TEST: begin
				if (st.cnt_zero) begin
					state_d = lcgfy_pkg::ST_SEED_MUL;
				end else if (st.cnt_bit0) begin
					state_d = lcgfy_pkg::ST_ACCM_MUL;
				end else begin
					state_d = lcgfy_pkg::ST_CURA_MUL;
				end
			end
			lcgfy_pkg::ST_ACCM_MUL: state_d = lcgfy_pkg::ST_ACCM_WB;
			lcgfy_pkg::ST_ACCM_WB:  state_d = lcgfy_pkg::ST_ACCA_MUL;
			lcgfy_pkg::ST_ACCA_MUL: state_d = lcgfy_pkg::ST_ACCA_WB;
			lcgfy_pkg::ST_ACCA_WB:  state_d = lcgfy_pkg::ST_CURA_MUL;
			lcgfy_pkg::ST_CURA_MUL: state_d = lcgfy_pkg::ST_CURA_WB;
			lcgfy_pkg::ST_CURA_WB:  state_d = lcgfy_pkg::ST_CURM_MUL;
			lcgfy_pkg::ST_CURM_MUL: state_d = lcgfy_pkg::ST_CURM_WB;
			lcgfy_pkg::ST_CURM_WB:  state_d = lcgfy_pkg::ST_JUMP_TEST;
			lcgfy_pkg::ST_SEED_MUL: state_d = lcgfy_pkg::ST_SEED_WB;
			lcgfy_pkg::ST_SEED_WB:  state_d = lcgfy_pkg::ST_INIT;
			lcgfy_pkg::ST_INIT: begin
				if (st.idx_last) state_d = lcgfy_pkg::ST_DRAW_MUL;
			end
			lcgfy_pkg::ST_DRAW_MUL: state_d = lcgfy_pkg::ST_DRAW_WB;
			lcgfy_pkg::ST_DRAW_WB:  state_d = lcgfy_pkg::ST_DIV;
			lcgfy_pkg::ST_DIV: begin
				if (st.div_last) state_d = lcgfy_pkg::ST_RD_I;
			end
			lcgfy_pkg::ST_RD_I: state_d = lcgfy_pkg::ST_RD_J;
			lcgfy_pkg::ST_RD_J: state_d = lcgfy_pkg::ST_WR_I;
			lcgfy_pkg::ST_WR_I: state_d = lcgfy_pkg::ST_WR_J;
			lcgfy_pkg::ST_WR_J: begin
				if (st.idx_shuf_last) begin
					state_d = lcgfy_pkg::ST_EMIT_RD;
				end else begin
					state_d = lcgfy_pkg::ST_DRAW_MUL;
				end
			end
			lcgfy_pkg::ST_EMIT_RD: state_d = lcgfy_pkg::ST_EMIT_LD;
			lcgfy_pkg::ST_EMIT_LD: state_d = lcgfy_pkg::ST_EMIT_WAIT;
			lcgfy_pkg::ST_EMIT_WAIT: begin
				if (!card_stall) begin
					state_d = st.idx_last ? lcgfy_pkg::ST_IDLE : lcgfy_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = lcgfy_pkg::ST_IDLE;
		endcase
	end

	// Output logic: handshake and datapath commands.
	always_comb begin
		start_stall    = (state_q != lcgfy_pkg::ST_IDLE);
		card_valid     = (state_q == lcgfy_pkg::ST_EMIT_WAIT);
		cmd.start_load = 1'b0;
		cmd.mul_op     = lcgfy_pkg::MOP_NONE;
		cmd.wb_op      = lcgfy_pkg::MOP_NONE;
		cmd.idx_clear  = 1'b0;
		cmd.idx_inc    = 1'b0;
		cmd.init_wr    = 1'b0;
		cmd.div_step   = 1'b0;
		cmd.rd_j       = 1'b0;
		cmd.hold_ti    = 1'b0;
		cmd.wr_i       = 1'b0;
		cmd.wr_j       = 1'b0;
		cmd.out_load   = 1'b0;
		case (state_q)
			lcgfy_pkg::ST_IDLE: begin
				cmd.start_load = start_valid;
				cmd.idx_clear  = start_valid;
			end
			lcgfy_pkg::ST_ACCM_MUL: cmd.mul_op = lcgfy_pkg::MOP_ACC_M;
			lcgfy_pkg::ST_ACCM_WB:  cmd.wb_op  = lcgfy_pkg::MOP_ACC_M;
			lcgfy_pkg::ST_ACCA_MUL: cmd.mul_op = lcgfy_pkg::MOP_ACC_A;
			lcgfy_pkg::ST_ACCA_WB:  cmd.wb_op  = lcgfy_pkg::MOP_ACC_A;
			lcgfy_pkg::ST_CURA_MUL: cmd.mul_op = lcgfy_pkg::MOP_CUR_A;
			lcgfy_pkg::ST_CURA_WB:  cmd.wb_op  = lcgfy_pkg::MOP_CUR_A;
			lcgfy_pkg::ST_CURM_MUL: cmd.mul_op = lcgfy_pkg::MOP_CUR_M;
			lcgfy_pkg::ST_CURM_WB:  cmd.wb_op  = lcgfy_pkg::MOP_CUR_M;
			lcgfy_pkg::ST_SEED_MUL: cmd.mul_op = lcgfy_pkg::MOP_SEED;
			lcgfy_pkg::ST_SEED_WB:  cmd.wb_op  = lcgfy_pkg::MOP_SEED;
			lcgfy_pkg::ST_INIT: begin
				cmd.init_wr   = 1'b1;
				cmd.idx_inc   = !st.idx_last;
				cmd.idx_clear = st.idx_last;
			end
			lcgfy_pkg::ST_DRAW_MUL: cmd.mul_op   = lcgfy_pkg::MOP_DRAW;
			lcgfy_pkg::ST_DRAW_WB:  cmd.wb_op    = lcgfy_pkg::MOP_DRAW;
			lcgfy_pkg::ST_DIV:      cmd.div_step = 1'b1;
			lcgfy_pkg::ST_RD_J: begin
				cmd.rd_j    = 1'b1;
				cmd.hold_ti = 1'b1;
			end
			lcgfy_pkg::ST_WR_I: cmd.wr_i = 1'b1;
			lcgfy_pkg::ST_WR_J: begin
				cmd.wr_j      = 1'b1;
				cmd.idx_clear = st.idx_shuf_last;
				cmd.idx_inc   = !st.idx_shuf_last;
			end
			lcgfy_pkg::ST_EMIT_LD: cmd.out_load = 1'b1;
			lcgfy_pkg::ST_EMIT_WAIT: begin
				cmd.idx_inc   = !card_stall && !st.idx_last;
				cmd.idx_clear = !card_stall && st.idx_last;
			end
			default: begin
			end
		endcase
	end

	// An accepted start makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start_valid && !start_stall) |=> start_stall)
		else $error("block not busy after start transfer");

	// A card is never offered while the block takes a new start.
	a_no_card_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		card_valid |-> start_stall)
		else $error("card offered while idle");

	// The final card transfer returns the block to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(card_valid && !card_stall && st.idx_last) |=> !start_stall)
		else $error("block not idle after final card");

endmodule

// ===== tb/lcg_fisher_yates_deck_shuffle_tb.sv =====
// Self-checking testbench for the LCG-driven Fisher-Yates deck shuffler.
`timescale 1ns / 1ps

module lcg_fisher_yates_deck_shuffle_tb;

	localparam time CLK_PERIOD  = 20ns;
	localparam time RUN_LIMIT   = 200ms;
	localparam int  TAIL_CYCLES = 40;
	localparam int  RANDOM_PER_PHASE = 70;

	// One emitted slot of the shuffled deck.
	typedef struct {
		logic [5:0] position;
		logic [5:0] card_index;
		logic [1:0] operation;
		logic [2:0] rank;
		logic [1:0] letter;
		logic       last;
	} card_t;

	logic               clk;
	logic               arst_n;
	logic               start_valid;
	logic               start_stall;
	logic signed [31:0] discard_count;
	logic               card_valid;
	logic               card_stall;
	logic [5:0]         position;
	logic [5:0]         card_index;
	logic [1:0]         operation;
	logic [2:0]         rank;
	logic [1:0]         letter;
	logic               last;

	// Predicted generator seed and the cards still owed by the block.
	logic [31:0] gen_seed;
	card_t       expected_cards[$];

	int send_idle_pct;
	int recv_stall_pct;
	int starts_sent;
	int cards_checked;
	int error_count;

	lcg_fisher_yates_deck_shuffle u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_valid  (start_valid),
		.start_stall  (start_stall),
		.discard_count(discard_count),
		.card_valid   (card_valid),
		.card_stall   (card_stall),
		.position     (position),
		.card_index   (card_index),
		.operation    (operation),
		.rank         (rank),
		.letter       (letter),
		.last         (last)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("Timeout at %0t with %0d cards outstanding.", $time, expected_cards.size());
		$display("FAIL");
		$finish;
	end

	// Advances a seed by n draws at once, squaring the recurrence bit by bit.
	function automatic logic [31:0] jump_seed(input logic [31:0] seed, input logic [31:0] n);
		logic [31:0] acc_m;
		logic [31:0] acc_a;
		logic [31:0] cur_m;
		logic [31:0] cur_a;
		acc_m = 32'd1;
		acc_a = 32'd0;
		cur_m = lcgfy_pkg::LCG_MULT;
		cur_a = lcgfy_pkg::LCG_INC;
		for (int b = 0; b < 32; b++) begin
			if (n[b]) begin
				acc_m = acc_m * cur_m;
				acc_a = acc_a * cur_m + cur_a;
			end
			cur_a = (cur_m + 32'd1) * cur_a;
			cur_m = cur_m * cur_m;
		end
		return acc_m * seed + acc_a;
	endfunction

	// Computes the deck that one start produces and queues its 64 cards.
	task automatic predict_shuffle(input logic signed [31:0] cnt);
		logic [5:0]  deck [lcgfy_pkg::DECK_SIZE];
		logic [31:0] skip;
		logic [14:0] draw_bits;
		logic [5:0]  held;
		int          j;
		card_t       c;
		// Negative counts discard nothing.
		skip = cnt[31] ? 32'd0 : cnt;
		gen_seed = jump_seed(gen_seed, skip);
		for (int i = 0; i < lcgfy_pkg::DECK_SIZE; i++)
			deck[i] = i[5:0];
		for (int i = 0; i < lcgfy_pkg::DECK_SIZE - 1; i++) begin
			gen_seed = gen_seed * lcgfy_pkg::LCG_MULT + lcgfy_pkg::LCG_INC;
			draw_bits = gen_seed[lcgfy_pkg::DRAW_LSB +: lcgfy_pkg::DRAW_W];
			j = i + int'(draw_bits) % (lcgfy_pkg::DECK_SIZE - i);
			held = deck[i];
			deck[i] = deck[j];
			deck[j] = held;
		end
		for (int i = 0; i < lcgfy_pkg::DECK_SIZE; i++) begin
			c.position   = i[5:0];
			c.card_index = deck[i];
			c.operation  = deck[i][5:4];
			c.rank       = {1'b0, deck[i][3:2]} + 3'd1;
			c.letter     = deck[i][1:0];
			c.last       = (i == lcgfy_pkg::DECK_SIZE - 1);
			expected_cards.push_back(c);
		end
	endtask

	// Offers one start, with a random gap first, and predicts it on transfer.
	task automatic send_start(input logic signed [31:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			start_valid <= 1'b0;
			discard_count <= $urandom;
			@(posedge clk);
		end
		start_valid <= 1'b1;
		discard_count <= cnt;
		forever begin
			@(posedge clk);
			if (start_stall === 1'b0)
				break;
		end
		predict_shuffle(cnt);
		starts_sent++;
	endtask

	// Drops valid and holds off until every owed card has been seen.
	task automatic wait_for_drain();
		start_valid <= 1'b0;
		while (expected_cards.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Picks a discard count, mostly small, with negative and full-range ones mixed in.
	function automatic logic signed [31:0] pick_count();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom_range(300);
			3:       v = $urandom_range(7);
			4:       v = {1'b1, 31'($urandom)};
			5:       v = $urandom;
			6:       v = 32'd1 << $urandom_range(30);
			7:       v = {1'b0, 31'($urandom)};
			8:       v = $urandom_range(65535);
			default: v = -$urandom_range(1, 50);
		endcase
		return v;
	endfunction

	task automatic run_random(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n; k++)
			send_start(pick_count());
	endtask

	// Field extremes, negative and large counts, and repeats that show the seed carrying over.
	task automatic test_directed_counts();
		logic [31:0] counts [$];
		counts = '{32'd0, 32'd0, 32'd1, 32'd2, 32'd3, 32'hffff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h4000_0000, 32'haaaa_aaaa, 32'h5555_5555, 32'd16,
			32'd255, 32'd256, 32'h0000_ffff, 32'h0001_0000, 32'h1234_5678,
			32'hffff_ff9c, 32'h0000_0001};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (counts[k])
			send_start(counts[k]);
	endtask

	task automatic test_random_no_idle();
		run_random(0, 0, RANDOM_PER_PHASE);
	endtask

	task automatic test_random_sender_idle();
		run_random(71, 0, RANDOM_PER_PHASE);
	endtask

	task automatic test_random_receiver_stall();
		run_random(0, 71, RANDOM_PER_PHASE);
	endtask

	task automatic test_random_both_idle();
		run_random(8, 8, RANDOM_PER_PHASE);
	endtask

	// Reports one field mismatch; unknown bits count as a mismatch.
	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	// Checks each card transfer against the oldest prediction, then drives the stall.
	always @(posedge clk) begin
		card_t e;
		if (arst_n === 1'b1 && card_valid === 1'b1 && card_stall === 1'b0) begin
			if (expected_cards.size() == 0) begin
				$display("%0t: unexpected card, actual position %0d card_index %0d",
					$time, position, card_index);
				error_count++;
			end else begin
				e = expected_cards.pop_front();
				check_field("position", e.position, position);
				check_field("card_index", e.card_index, card_index);
				check_field("operation", e.operation, operation);
				check_field("rank", e.rank, rank);
				check_field("letter", e.letter, letter);
				check_field("last", e.last, last);
				cards_checked++;
			end
		end
		card_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Test sequence.
	initial begin
		arst_n        <= 1'b0;
		start_valid   <= 1'b0;
		discard_count <= 32'sd0;
		card_stall    <= 1'b0;
		gen_seed       = 32'd1;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		starts_sent    = 0;
		cards_checked  = 0;
		error_count    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_counts();
		wait_for_drain();
		test_random_no_idle();
		test_random_sender_idle();
		wait_for_drain();
		test_random_receiver_stall();
		test_random_both_idle();
		wait_for_drain();

		if (expected_cards.size() != 0) begin
			$display("%0t: %0d cards never arrived", $time, expected_cards.size());
			error_count++;
		end
		$display("Ran %0d shuffle starts with directed, negative and large discard counts,",
			starts_sent);
		$display("under four idle and stall mixes; %0d cards compared, %0d mismatches.",
			cards_checked, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
